// ===== design/mpa_pkg.sv =====
// ----------------------------------------------------------------------------
// mpa_pkg: shared types and constants for the max pool with argmax block
// Sizes, stage payload structs, register indexes and the reciprocal table
// used to test window alignment without a divider.
// ----------------------------------------------------------------------------
package mpa_pkg;

  // Storage limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_KERNEL = 8;

  // Fixed field widths
  localparam int PIX_W = 16;
  localparam int DIM_W = 11;
  localparam int KER_W = 4;
  localparam int IDX_W = 20;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W = DIM_W;

  // Derived widths
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int BANK_W    = $clog2(MAX_KERNEL);
  localparam int POS_MAX_W = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int SUM_W     = DIM_W + 1;
  localparam int DIV_W     = POS_MAX_W + KER_W;
  localparam int MUL_W     = ROW_W + DIM_W;

  // Reciprocal scaling: error of ceil(2^S/s) times any position stays below 2^S
  localparam int RECIP_SHIFT = POS_MAX_W + KER_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int RECIP_ONE   = 2 ** RECIP_SHIFT;
  localparam int PROD_W      = POS_MAX_W + RECIP_W;

  // Register reset values
  localparam int RESET_HEIGHT = 1024;
  localparam int RESET_WIDTH  = 1024;
  localparam int RESET_KERNEL = 2;
  localparam int RESET_STRIDE = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMG_HEIGHT    = 3'd0,
    REG_IMG_WIDTH     = 3'd1,
    REG_KERNEL_HEIGHT = 3'd2,
    REG_KERNEL_WIDTH  = 3'd3,
    REG_STRIDE_ROWS   = 3'd4,
    REG_STRIDE_COLS   = 3'd5
  } reg_idx_t;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef logic [ROW_W-1:0]        row_t;
  typedef logic [COL_W-1:0]        col_t;
  typedef logic [DIM_W-1:0]        dim_t;
  typedef logic [KER_W-1:0]        ker_t;
  typedef pix_t [MAX_KERNEL-1:0]   line_rd_t;

  // Effective (clamped) configuration
  typedef struct packed {
    dim_t h;
    dim_t w;
    ker_t kh;
    ker_t kw;
    ker_t sr;
    ker_t sc;
  } cfg_t;

  // Stage 1: accepted pixel with its position
  typedef struct packed {
    pix_t pixel;
    row_t row;
    col_t col;
    row_t xr;
    col_t xc;
    logic win_ok;
    logic last;
    ker_t kh;
    ker_t kw;
    ker_t sr;
    ker_t sc;
    dim_t w;
  } s1_t;

  // Column maximum kept in the row history
  typedef struct packed {
    pix_t value;
    row_t row;
  } cmax_t;

  // Running column maximum; entry k covers the pixel row and k rows above
  typedef cmax_t [MAX_KERNEL-1:0] cmax_col_t;

  // Stage 2: column maxima for every window height and alignment quotients
  typedef struct packed {
    cmax_col_t colmax;
    col_t col;
    row_t xr;
    col_t xc;
    row_t qr;
    col_t qc;
    logic win_ok;
    logic last;
    ker_t sr;
    ker_t sc;
    ker_t kh;
    ker_t kw;
    dim_t w;
  } s2_t;

  // Stage 3: window decision
  typedef struct packed {
    col_t col;
    logic hit;
    logic last;
    ker_t kh;
    ker_t kw;
    dim_t w;
  } s3_t;

  // Stage 4: window winner
  typedef struct packed {
    pix_t value;
    row_t row;
    col_t col;
    logic last;
    dim_t w;
  } s4_t;

  // ceil(2^RECIP_SHIFT / s) for strides 1..15
  function automatic logic [RECIP_W-1:0] recip(input ker_t s);
    logic [RECIP_W-1:0] m;
    case (s)
      4'd2:    m = RECIP_W'((RECIP_ONE + 1) / 2);
      4'd3:    m = RECIP_W'((RECIP_ONE + 2) / 3);
      4'd4:    m = RECIP_W'((RECIP_ONE + 3) / 4);
      4'd5:    m = RECIP_W'((RECIP_ONE + 4) / 5);
      4'd6:    m = RECIP_W'((RECIP_ONE + 5) / 6);
      4'd7:    m = RECIP_W'((RECIP_ONE + 6) / 7);
      4'd8:    m = RECIP_W'((RECIP_ONE + 7) / 8);
      4'd9:    m = RECIP_W'((RECIP_ONE + 8) / 9);
      4'd10:   m = RECIP_W'((RECIP_ONE + 9) / 10);
      4'd11:   m = RECIP_W'((RECIP_ONE + 10) / 11);
      4'd12:   m = RECIP_W'((RECIP_ONE + 11) / 12);
      4'd13:   m = RECIP_W'((RECIP_ONE + 12) / 13);
      4'd14:   m = RECIP_W'((RECIP_ONE + 13) / 14);
      4'd15:   m = RECIP_W'((RECIP_ONE + 14) / 15);
      default: m = RECIP_W'(RECIP_ONE);
    endcase
    return m;
  endfunction

  // floor(x / s) by reciprocal multiply; exact over the position range
  function automatic logic [POS_MAX_W-1:0] quot(input logic [POS_MAX_W-1:0] x,
                                                input ker_t s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(recip(s));
    return p[RECIP_SHIFT +: POS_MAX_W];
  endfunction

endpackage

// ===== design/mpa_line_store.sv =====
// ----------------------------------------------------------------------------
// mpa_line_store: banked line buffer
// One bank per window row (row mod MAX_KERNEL). Each transfer writes the new
// pixel into its row's bank and reads every bank at the same column.
// ----------------------------------------------------------------------------
module mpa_line_store
  import mpa_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [BANK_W-1:0] wr_bank,
  input  col_t              addr,
  input  pix_t              wdata,
  output line_rd_t          rdata
);

  // One single-port-write, registered-read array per bank
  for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
    pix_t mem [MAX_WIDTH];
    pix_t rd;

    always_ff @(posedge clk) begin
      if (en && (wr_bank == BANK_W'(b))) begin
        mem[addr] <= wdata;
      end
      if (en) begin
        rd <= mem[addr];
      end
    end

    assign rdata[b] = rd;
  end

endmodule

// ===== design/mpa_position.sv =====
// ----------------------------------------------------------------------------
// mpa_position: raster position tracking and stage 1 register
// Resolves the row and column of each accepted pixel, flags whether it
// closes a window and whether that window is the last of the image.
// ----------------------------------------------------------------------------
module mpa_position
  import mpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              accept,
  input  pix_t              pixel,
  input  logic              start_of_image,
  output logic [BANK_W-1:0] wr_bank,
  output col_t              wr_addr,
  output s1_t               s1
);

  row_t row_pos;
  col_t col_pos;
  row_t row_pos_next;
  col_t col_pos_next;

  dim_t r_a;
  dim_t c_a;
  dim_t r_n;
  dim_t c_n;
  logic [SUM_W-1:0] r1;
  logic [SUM_W-1:0] c1;
  logic row_ok;
  logic col_ok;
  logic fit;
  logic row_last;
  logic col_last;

  // Position of the incoming pixel and the one after it
  always_comb begin
    r_a = start_of_image ? '0 : DIM_W'(row_pos);
    c_a = start_of_image ? '0 : DIM_W'(col_pos);
    // width may have shrunk since the last transfer
    if (c_a >= cfg.w) begin
      c_a = '0;
      r_a = r_a + DIM_W'(1);
    end
    if (r_a >= cfg.h) begin
      r_a = '0;
    end
    c_n = c_a + DIM_W'(1);
    r_n = r_a;
    if (c_n >= cfg.w) begin
      c_n = '0;
      r_n = r_a + DIM_W'(1);
      if (r_n >= cfg.h) begin
        r_n = '0;
      end
    end
    row_pos_next = ROW_W'(r_n);
    col_pos_next = COL_W'(c_n);
  end

  // Window closing and last-window flags
  always_comb begin
    r1       = SUM_W'(r_a) + SUM_W'(1);
    c1       = SUM_W'(c_a) + SUM_W'(1);
    row_ok   = r1 >= SUM_W'(cfg.kh);
    col_ok   = c1 >= SUM_W'(cfg.kw);
    fit      = (DIM_W'(cfg.kh) <= cfg.h) && (DIM_W'(cfg.kw) <= cfg.w);
    row_last = (SUM_W'(r_a) + SUM_W'(cfg.sr)) >= SUM_W'(cfg.h);
    col_last = (SUM_W'(c_a) + SUM_W'(cfg.sc)) >= SUM_W'(cfg.w);
  end

  assign wr_bank = r_a[BANK_W-1:0];
  assign wr_addr = COL_W'(c_a);

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.pixel  <= pixel;
      s1.row    <= ROW_W'(r_a);
      s1.col    <= COL_W'(c_a);
      s1.xr     <= ROW_W'(r1 - SUM_W'(cfg.kh));
      s1.xc     <= COL_W'(c1 - SUM_W'(cfg.kw));
      s1.win_ok <= fit && row_ok && col_ok;
      s1.last   <= row_last && col_last;
      s1.kh     <= cfg.kh;
      s1.kw     <= cfg.kw;
      s1.sr     <= cfg.sr;
      s1.sc     <= cfg.sc;
      s1.w      <= cfg.w;
    end
  end

  a_start_origin: assert property (@(posedge clk) disable iff (rst)
    accept && start_of_image |=> (s1.row == '0) && (s1.col == '0))
    else $error("start of image did not land at the origin");

endmodule

// ===== design/mpa_col_max.sv =====
// ----------------------------------------------------------------------------
// mpa_col_max: vertical maximum over the window rows
// Runs the largest sample up the current column (upper row wins ties) and
// keeps it for every window height, then forms the alignment quotients for
// stage 3.
// ----------------------------------------------------------------------------
module mpa_col_max
  import mpa_pkg::*;
(
  input  logic     clk,
  input  logic     load,
  input  s1_t      s1,
  input  line_rd_t rdata,
  output s2_t      s2
);

  pix_t      run_v;
  row_t      run_r;
  pix_t      cand;
  cmax_col_t colmax;
  row_t      qr;
  col_t      qc;

  // Walk up the column; older rows replace on equal value. The height in
  // force when the window closes picks one of the running maxima.
  always_comb begin
    run_v            = s1.pixel;
    run_r            = s1.row;
    cand             = '0;
    colmax[0].value  = s1.pixel;
    colmax[0].row    = s1.row;
    for (int d = 1; d < MAX_KERNEL; d++) begin
      cand = rdata[BANK_W'(s1.row[BANK_W-1:0] - BANK_W'(d))];
      if ($signed(cand) >= $signed(run_v)) begin
        run_v = cand;
        run_r = s1.row - ROW_W'(d);
      end
      colmax[d].value = run_v;
      colmax[d].row   = run_r;
    end
  end

  // Quotients of the window offsets by the strides
  always_comb begin
    qr = ROW_W'(quot(POS_MAX_W'(s1.xr), s1.sr));
    qc = COL_W'(quot(POS_MAX_W'(s1.xc), s1.sc));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2.colmax <= colmax;
      s2.col    <= s1.col;
      s2.xr     <= s1.xr;
      s2.xc     <= s1.xc;
      s2.qr     <= qr;
      s2.qc     <= qc;
      s2.win_ok <= s1.win_ok;
      s2.last   <= s1.last;
      s2.sr     <= s1.sr;
      s2.sc     <= s1.sc;
      s2.kh     <= s1.kh;
      s2.kw     <= s1.kw;
      s2.w      <= s1.w;
    end
  end

endmodule

// ===== design/mpa_win_max.sv =====
// ----------------------------------------------------------------------------
// mpa_win_max: horizontal reduction, argmax and result register
// Keeps the column maxima of the current row, decides stride alignment,
// picks the window winner (first in raster order on ties) and forms the
// flat index row * width + col.
// ----------------------------------------------------------------------------
module mpa_win_max
  import mpa_pkg::*;
(
  input  logic             clk,
  input  logic             s3_load,
  input  logic             s4_load,
  input  logic             out_load,
  input  s2_t              s2,
  output logic             s3_hit,
  output pix_t             max_value,
  output logic [IDX_W-1:0] max_index,
  output logic             last_in_image
);

  s3_t       s3;
  s4_t       s4;
  cmax_col_t hist [MAX_KERNEL];

  logic row_div;
  logic col_div;
  logic [BANK_W-1:0] depth;
  pix_t best_v;
  row_t best_r;
  logic [BANK_W-1:0] best_j;
  logic [MUL_W-1:0] flat;

  // Offset is a multiple of the stride when quotient times stride gives it back
  always_comb begin
    row_div = (DIV_W'(s2.qr) * DIV_W'(s2.sr)) == DIV_W'(s2.xr);
    col_div = (DIV_W'(s2.qc) * DIV_W'(s2.sc)) == DIV_W'(s2.xc);
  end

  // Stage 3 item and row history shift together
  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3.col  <= s2.col;
      s3.hit  <= s2.win_ok && row_div && col_div;
      s3.last <= s2.last;
      s3.kh   <= s2.kh;
      s3.kw   <= s2.kw;
      s3.w    <= s2.w;
      hist[0] <= s2.colmax;
      for (int k = 1; k < MAX_KERNEL; k++) begin
        hist[k] <= hist[k-1];
      end
    end
  end

  assign s3_hit = s3.hit;

  // Entry j holds column col - j; the window height picks its column maximum.
  // On equal value a left column wins unless its row is lower.
  always_comb begin
    depth  = BANK_W'(s3.kh - KER_W'(1));
    best_v = hist[0][depth].value;
    best_r = hist[0][depth].row;
    best_j = '0;
    for (int j = 1; j < MAX_KERNEL; j++) begin
      if ((KER_W'(j) < s3.kw) &&
          (($signed(hist[j][depth].value) > $signed(best_v)) ||
           ((hist[j][depth].value == best_v) && (hist[j][depth].row <= best_r)))) begin
        best_v = hist[j][depth].value;
        best_r = hist[j][depth].row;
        best_j = BANK_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_load) begin
      s4.value <= best_v;
      s4.row   <= best_r;
      s4.col   <= s3.col - COL_W'(best_j);
      s4.last  <= s3.last;
      s4.w     <= s3.w;
    end
  end

  // Flat index
  assign flat = (MUL_W'(s4.row) * MUL_W'(s4.w)) + MUL_W'(s4.col);

  always_ff @(posedge clk) begin
    if (out_load) begin
      max_value     <= s4.value;
      max_index     <= flat[IDX_W-1:0];
      last_in_image <= s4.last;
    end
  end

endmodule

// ===== design/max_pool_with_argmax.sv =====
// ----------------------------------------------------------------------------
// max_pool_with_argmax: streaming 2D max pooling with argmax
//
//   channel   direction  handshake                    payload
//   pixel     in         pixel_valid / pixel_stall    pixel, start_of_image
//   result    out        result_valid / result_stall  max_value, max_index,
//                                                     last_in_image
//   cfg       in         cfg_write                    cfg_index, cfg_data
//
// One pixel transfer per clock while pixel_stall is low; the line store reads
// all window rows of a column in one registered read from its MAX_KERNEL banks.
// A result moves from the stage 1 register through stages 2, 3 and 4 into the
// output register, and leaves from there.
// Synchronous reset clears position and stage valids and loads the configuration
// reset values; the line store is not cleared and needs no clearing pass.
// A stalled result holds the output; pixels keep flowing until the stage
// registers fill, and windows that emit nothing never occupy the tail.
// ----------------------------------------------------------------------------
module max_pool_with_argmax
  import mpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  pix_t                 pixel,
  input  logic                 start_of_image,
  output logic                 result_valid,
  input  logic                 result_stall,
  output pix_t                 max_value,
  output logic [IDX_W-1:0]     max_index,
  output logic                 last_in_image,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers
  dim_t img_height;
  dim_t img_width;
  ker_t kernel_height;
  ker_t kernel_width;
  ker_t stride_rows;
  ker_t stride_cols;
  cfg_t cfg;

  // Pipeline control
  logic s1_valid;
  logic s2_valid;
  logic s3_valid;
  logic s4_valid;
  logic accept;
  logic out_free;
  logic s4_go;
  logic s4_free;
  logic s3_go;
  logic s3_free;
  logic s2_go;
  logic s2_free;
  logic s1_go;
  logic s1_free;
  logic s3_hit;

  // Datapath links
  logic [BANK_W-1:0] wr_bank;
  col_t              wr_addr;
  line_rd_t          rdata;
  s1_t               s1;
  s2_t               s2;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      img_height    <= DIM_W'(RESET_HEIGHT);
      img_width     <= DIM_W'(RESET_WIDTH);
      kernel_height <= KER_W'(RESET_KERNEL);
      kernel_width  <= KER_W'(RESET_KERNEL);
      stride_rows   <= KER_W'(RESET_STRIDE);
      stride_cols   <= KER_W'(RESET_STRIDE);
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_IMG_HEIGHT:    img_height    <= cfg_data[DIM_W-1:0];
        REG_IMG_WIDTH:     img_width     <= cfg_data[DIM_W-1:0];
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[KER_W-1:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[KER_W-1:0];
        REG_STRIDE_ROWS:   stride_rows   <= cfg_data[KER_W-1:0];
        REG_STRIDE_COLS:   stride_cols   <= cfg_data[KER_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one; sizes saturate at the storage limits
  always_comb begin
    cfg.h  = (img_height == '0) ? DIM_W'(1) :
             (img_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : img_height;
    cfg.w  = (img_width == '0) ? DIM_W'(1) :
             (img_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : img_width;
    cfg.kh = (kernel_height == '0) ? KER_W'(1) :
             (kernel_height > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : kernel_height;
    cfg.kw = (kernel_width == '0) ? KER_W'(1) :
             (kernel_width > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : kernel_width;
    cfg.sr = (stride_rows == '0) ? KER_W'(1) : stride_rows;
    cfg.sc = (stride_cols == '0) ? KER_W'(1) : stride_cols;
  end

  // Stage advance: a stage moves when the next one is empty or moving; stage 3 also moves on a miss
  always_comb begin
    out_free    = !result_valid || !result_stall;
    s4_go       = s4_valid && out_free;
    s4_free     = !s4_valid || s4_go;
    s3_go       = s3_valid && (!s3_hit || s4_free);
    s3_free     = !s3_valid || s3_go;
    s2_go       = s2_valid && s3_free;
    s2_free     = !s2_valid || s2_go;
    s1_go       = s1_valid && s2_free;
    s1_free     = !s1_valid || s1_go;
    pixel_stall = !s1_free;
    accept      = pixel_valid && !pixel_stall;
  end

  // Stage valids; windows that emit nothing drop out after stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_free)  s1_valid     <= accept;
      if (s2_free)  s2_valid     <= s1_go;
      if (s3_free)  s3_valid     <= s2_go;
      if (s4_free)  s4_valid     <= s3_go && s3_hit;
      if (out_free) result_valid <= s4_go;
    end
  end

  mpa_position u_position (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .pixel          (pixel),
    .start_of_image (start_of_image),
    .wr_bank        (wr_bank),
    .wr_addr        (wr_addr),
    .s1             (s1)
  );

  mpa_line_store u_line_store (
    .clk     (clk),
    .en      (accept),
    .wr_bank (wr_bank),
    .addr    (wr_addr),
    .wdata   (pixel),
    .rdata   (rdata)
  );

  mpa_col_max u_col_max (
    .clk   (clk),
    .load  (s1_go),
    .s1    (s1),
    .rdata (rdata),
    .s2    (s2)
  );

  mpa_win_max u_win_max (
    .clk           (clk),
    .s3_load       (s2_go),
    .s4_load       (s3_go && s3_hit),
    .out_load      (s4_go),
    .s2            (s2),
    .s3_hit        (s3_hit),
    .max_value     (max_value),
    .max_index     (max_index),
    .last_in_image (last_in_image)
  );

  a_front_open: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !pixel_stall)
    else $error("pixel stalled with an empty front stage");

  a_tail_hold: assert property (@(posedge clk) disable iff (rst)
    s4_valid && result_valid && result_stall |=> s4_valid && result_valid)
    else $error("pending window lost while the result was stalled");

  a_no_empty_emit: assert property (@(posedge clk) disable iff (rst)
    s4_go |-> s4_valid && out_free)
    else $error("result register loaded without a pending window");

endmodule
